/* rtl/core/ffthr_pkg.sv */
package ffthr_pkg;

  localparam int DATA_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int GRAV_W    = 20;
  localparam int THR_W     = 16;
  localparam int NUM_LANES = 7;
  localparam int PROD_W    = DATA_W + GAIN_W + 1;
  localparam int SUMSQ_W   = 48;
  localparam int RAD_W     = 60;
  localparam int ROOT_W    = 30;
  localparam int REM_W     = 32;
  localparam int QUO_W     = 16;
  localparam int DREM_W    = GRAV_W + QUO_W;

  // register indexes
  localparam logic [2:0] REG_VEL_GAIN  = 3'd0;
  localparam logic [2:0] REG_ACC_GAIN  = 3'd1;
  localparam logic [2:0] REG_YAW_GAIN  = 3'd2;
  localparam logic [2:0] REG_GRAVITY   = 3'd3;
  localparam logic [2:0] REG_HOVER_COL = 3'd4;
  localparam logic [2:0] REG_HOVER_BASE = 3'd5;
  localparam logic [2:0] REG_THRUST_MAX = 3'd6;

  // reset values
  localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd4096;
  localparam logic [GRAV_W-1:0] RST_GRAVITY   = 20'd251136;
  localparam logic [THR_W-1:0]  RST_HOVER_COL = 16'd8192;
  localparam logic [THR_W-1:0]  RST_THR_MAX   = 16'd16384;

  // scaled lanes plus the enable flag travel alongside the thrust path
  typedef struct packed {
    logic                                  en;
    logic [NUM_LANES-1:0][DATA_W-1:0]      ff;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [RAD_W-1:0]   x;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

  typedef struct packed {
    side_t              side;
    logic               ovf;
    logic [DREM_W-1:0]  rem;
    logic [DREM_W-1:0]  d;
    logic [QUO_W-1:0]   q;
  } dv_t;

  // round half up, then saturate to the signed data range
  function automatic logic [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    r  = (p + PROD_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    hi = PROD_W'((1 << (DATA_W - 1)) - 1);
    lo = -hi - PROD_W'(1);
    if (r > hi) begin
      round_sat = hi[DATA_W-1:0];
    end else if (r < lo) begin
      round_sat = lo[DATA_W-1:0];
    end else begin
      round_sat = r[DATA_W-1:0];
    end
  endfunction

endpackage

/* rtl/core/ffthr_front.sv */
module ffthr_front (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic                                        in_req,
  input  logic [ffthr_pkg::NUM_LANES-1:0][ffthr_pkg::DATA_W-1:0] in_lane,
  input  logic [ffthr_pkg::GAIN_W-1:0]                vel_gain,
  input  logic [ffthr_pkg::GAIN_W-1:0]                acc_gain,
  input  logic [ffthr_pkg::GAIN_W-1:0]                yaw_gain,
  input  logic [ffthr_pkg::GRAV_W-1:0]                g_eff,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output ffthr_pkg::sq_t                              out_data
);

  localparam int SQ_W = 2 * ffthr_pkg::DATA_W + 2;

  logic a_vld;
  logic a_en;
  logic signed [ffthr_pkg::PROD_W-1:0] a_prod [ffthr_pkg::NUM_LANES];
  logic [SQ_W-1:0] a_sq [3];
  logic a_load;
  logic b_load;
  logic [ffthr_pkg::GAIN_W-1:0] gain_sel [ffthr_pkg::NUM_LANES];
  logic signed [ffthr_pkg::DATA_W:0] vert;
  logic [ffthr_pkg::SUMSQ_W-1:0] sum_sq;
  ffthr_pkg::side_t side_n;

  assign b_load   = !out_valid || out_ready;
  assign a_load   = !a_vld || b_load;
  assign in_ready = a_load;

  // lanes 0..2 velocity, 3..5 acceleration, 6 yaw
  always_comb begin
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) begin
      if (i < 3) begin
        gain_sel[i] = vel_gain;
      end else if (i < 6) begin
        gain_sel[i] = acc_gain;
      end else begin
        gain_sel[i] = yaw_gain;
      end
    end
  end

  assign vert = $signed({in_lane[5][ffthr_pkg::DATA_W-1], in_lane[5]})
              + $signed({(ffthr_pkg::DATA_W + 1 - ffthr_pkg::GRAV_W)'(0), g_eff});

  // stage A: gain products and squares
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_load) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_en <= in_req;
      for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) begin
        a_prod[i] <= ffthr_pkg::PROD_W'($signed(in_lane[i]) * $signed({1'b0, gain_sel[i]}));
      end
      a_sq[0] <= SQ_W'($signed(in_lane[3]) * $signed(in_lane[3]));
      a_sq[1] <= SQ_W'($signed(in_lane[4]) * $signed(in_lane[4]));
      a_sq[2] <= SQ_W'(vert * vert);
    end
  end

  // stage B: round and saturate, sum of squares
  always_comb begin
    side_n.en = a_en;
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) begin
      side_n.ff[i] = a_en ? ffthr_pkg::round_sat(a_prod[i]) : '0;
    end
  end

  assign sum_sq = ffthr_pkg::SUMSQ_W'(a_sq[0]) + ffthr_pkg::SUMSQ_W'(a_sq[1])
                + ffthr_pkg::SUMSQ_W'(a_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_data.side <= side_n;
      out_data.x    <= {sum_sq, 12'd0};
      out_data.rem  <= '0;
      out_data.root <= '0;
    end
  end

endmodule

/* rtl/core/ffthr_sqrt_cell.sv */
module ffthr_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffthr_pkg::sq_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ffthr_pkg::sq_t  out_data
);

  localparam int W = ffthr_pkg::REM_W + 2;

  logic load;
  logic [W-1:0] nxt;
  logic [W-1:0] trial;
  ffthr_pkg::sq_t res;

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  // one root bit: bring down two radicand bits, try subtracting 4r+1
  always_comb begin
    nxt   = {in_data.rem, in_data.x[ffthr_pkg::RAD_W-1 -: 2]};
    trial = {(W - ffthr_pkg::ROOT_W - 2)'(0), in_data.root, 2'b01};
    res.side = in_data.side;
    res.x    = {in_data.x[ffthr_pkg::RAD_W-3:0], 2'b00};
    if (nxt >= trial) begin
      res.rem  = ffthr_pkg::REM_W'(nxt - trial);
      res.root = {in_data.root[ffthr_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = nxt[ffthr_pkg::REM_W-1:0];
      res.root = {in_data.root[ffthr_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* rtl/core/ffthr_div_cell.sv */
module ffthr_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffthr_pkg::dv_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ffthr_pkg::dv_t  out_data
);

  logic load;
  ffthr_pkg::dv_t res;

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  // one quotient bit: restoring compare and subtract, divisor moves down
  always_comb begin
    res      = in_data;
    res.d    = {1'b0, in_data.d[ffthr_pkg::DREM_W-1:1]};
    if (in_data.rem >= in_data.d) begin
      res.rem = in_data.rem - in_data.d;
      res.q   = {in_data.q[ffthr_pkg::QUO_W-2:0], 1'b1};
    end else begin
      res.q   = {in_data.q[ffthr_pkg::QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* rtl/core/flight_feedforward_thrust.sv */
// Pipeline: 2 front stages, 30 square root cells, 2 scaling stages, 16 divider cells and
// 1 output register lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle while the output is not stalled; every stage holds one
// beat and takes its ready combinationally from the next, so the pipeline keeps filling while an output waits.
// Reset: synchronous, clears all stage valid flags and loads the register defaults.
module flight_feedforward_thrust (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [167:0]  s_axis_tdata,  // vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, yaw_rate
  input  logic          s_axis_tuser,  // valid_req
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [183:0]  m_axis_tdata,  // vel_ff_x/y/z, acc_ff_x/y/z, yaw_ff, thrust_ff
  output logic          m_axis_tuser,  // enabled
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [19:0]   cfg_data
);

  localparam int NSQ = ffthr_pkg::ROOT_W;
  localparam int NDV = ffthr_pkg::QUO_W;
  localparam int MP_W = ffthr_pkg::THR_W + ffthr_pkg::ROOT_W;
  localparam int NUM_W = MP_W + 1 - 6;

  // configuration registers
  logic [ffthr_pkg::GAIN_W-1:0] vel_gain;
  logic [ffthr_pkg::GAIN_W-1:0] acc_gain;
  logic [ffthr_pkg::GAIN_W-1:0] yaw_gain;
  logic [ffthr_pkg::GRAV_W-1:0] gravity;
  logic [ffthr_pkg::THR_W-1:0]  hover_col;
  logic [ffthr_pkg::THR_W-1:0]  hover_base;
  logic [ffthr_pkg::THR_W-1:0]  thrust_max;
  logic [ffthr_pkg::GRAV_W-1:0] g_eff;
  logic [ffthr_pkg::THR_W-1:0]  base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_gain   <= ffthr_pkg::RST_GAIN;
      acc_gain   <= ffthr_pkg::RST_GAIN;
      yaw_gain   <= ffthr_pkg::RST_GAIN;
      gravity    <= ffthr_pkg::RST_GRAVITY;
      hover_col  <= ffthr_pkg::RST_HOVER_COL;
      hover_base <= '0;
      thrust_max <= ffthr_pkg::RST_THR_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffthr_pkg::REG_VEL_GAIN:   vel_gain   <= cfg_data[15:0];
        ffthr_pkg::REG_ACC_GAIN:   acc_gain   <= cfg_data[15:0];
        ffthr_pkg::REG_YAW_GAIN:   yaw_gain   <= cfg_data[15:0];
        ffthr_pkg::REG_GRAVITY:    gravity    <= cfg_data;
        ffthr_pkg::REG_HOVER_COL:  hover_col  <= cfg_data[15:0];
        ffthr_pkg::REG_HOVER_BASE: hover_base <= cfg_data[15:0];
        ffthr_pkg::REG_THRUST_MAX: thrust_max <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // zero gravity acts as the smallest step
  assign g_eff = (gravity == '0) ? ffthr_pkg::GRAV_W'(1) : gravity;
  assign base  = (hover_base != '0) ? hover_base : hover_col;

  // front: gain products, saturation, sum of squares
  logic [ffthr_pkg::NUM_LANES-1:0][ffthr_pkg::DATA_W-1:0] in_lane;
  logic           sq_vld [NSQ+1];
  logic           sq_rdy [NSQ+1];
  ffthr_pkg::sq_t sq_dat [NSQ+1];

  always_comb begin
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) begin
      in_lane[i] = s_axis_tdata[i*ffthr_pkg::DATA_W +: ffthr_pkg::DATA_W];
    end
  end

  ffthr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (s_axis_tuser),
    .in_lane   (in_lane),
    .vel_gain  (vel_gain),
    .acc_gain  (acc_gain),
    .yaw_gain  (yaw_gain),
    .g_eff     (g_eff),
    .out_valid (sq_vld[0]),
    .out_ready (sq_rdy[0]),
    .out_data  (sq_dat[0])
  );

  // square root chain, one root bit per cell
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    ffthr_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_vld[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_dat[k]),
      .out_valid (sq_vld[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_dat[k+1])
    );
  end

  // stage M1: base times magnitude
  logic              m1_vld;
  logic              m1_load;
  ffthr_pkg::side_t  m1_side;
  logic [MP_W-1:0]   m1_prod;

  // stage M2: add half divisor, drop 6 bits, overflow check
  logic              m2_vld;
  logic              m2_load;
  logic [NUM_W-1:0]  num;
  logic           dv_vld [NDV+1];
  logic           dv_rdy [NDV+1];
  ffthr_pkg::dv_t dv_dat [NDV+1];

  assign m1_load     = !m1_vld || m2_load;
  assign sq_rdy[NSQ] = m1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (m1_load) begin
      m1_vld <= sq_vld[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (m1_load) begin
      m1_side <= sq_dat[NSQ].side;
      m1_prod <= MP_W'(base * sq_dat[NSQ].root);
    end
  end

  assign m2_load   = !m2_vld || dv_rdy[0];
  assign dv_vld[0] = m2_vld;
  assign num = NUM_W'(({1'b0, m1_prod} + (MP_W + 1)'({g_eff, 5'd0})) >> 6);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (m2_load) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_load) begin
      dv_dat[0].side <= m1_side;
      dv_dat[0].ovf  <= num >= NUM_W'({g_eff, 16'd0});
      dv_dat[0].rem  <= num[ffthr_pkg::DREM_W-1:0];
      dv_dat[0].d    <= {1'b0, g_eff, 15'd0};
      dv_dat[0].q    <= '0;
    end
  end

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < NDV; k++) begin : g_div
    ffthr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_vld[k]),
      .in_ready  (dv_rdy[k]),
      .in_data   (dv_dat[k]),
      .out_valid (dv_vld[k+1]),
      .out_ready (dv_rdy[k+1]),
      .out_data  (dv_dat[k+1])
    );
  end

  // output register: clamp thrust, zero on invalid setpoint
  logic                        o_load;
  logic [ffthr_pkg::THR_W-1:0] thr;
  ffthr_pkg::dv_t              fin;

  assign fin          = dv_dat[NDV];
  assign o_load       = !m_axis_tvalid || m_axis_tready;
  assign dv_rdy[NDV]  = o_load;

  always_comb begin
    if (!fin.side.en) begin
      thr = '0;
    end else if (fin.ovf || (fin.q > thrust_max)) begin
      thr = thrust_max;
    end else begin
      thr = fin.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (o_load) begin
      m_axis_tvalid <= dv_vld[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      m_axis_tdata <= {thr, fin.side.ff};
      m_axis_tuser <= fin.side.en;
    end
  end

endmodule

/* tb/sv/ffthr_checker.sv */
module ffthr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [183:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [19:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ffthr_pkg::DATA_W-1:0] ff [ffthr_pkg::NUM_LANES];
    logic [ffthr_pkg::THR_W-1:0]  thrust;
    logic                         en;
  } setpoint_ff_t;

  logic [ffthr_pkg::GAIN_W-1:0] vel_gain, acc_gain, yaw_gain_r;
  logic [ffthr_pkg::GRAV_W-1:0] grav;
  logic [ffthr_pkg::THR_W-1:0]  hover_col, hover_base, thr_max;

  setpoint_ff_t ff_queue [$];

  assign pending = ff_queue.size();

  function automatic longint sx(logic [ffthr_pkg::DATA_W-1:0] v);
    return longint'($signed(v));
  endfunction

  // gain product, round half up, saturate to data range
  function automatic logic [ffthr_pkg::DATA_W-1:0] scale_lane(
      logic [ffthr_pkg::DATA_W-1:0] v, logic [ffthr_pkg::GAIN_W-1:0] g);
    longint p, r, hi, lo;
    p  = sx(v) * longint'(g) + (64'sd1 <<< (ffthr_pkg::GAIN_FRAC - 1));
    r  = p >>> ffthr_pkg::GAIN_FRAC;
    hi = (64'sd1 <<< (ffthr_pkg::DATA_W - 1)) - 1;
    lo = -hi - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[ffthr_pkg::DATA_W-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [ffthr_pkg::THR_W-1:0] thrust_from_accel(
      logic [ffthr_pkg::DATA_W-1:0] ax, logic [ffthr_pkg::DATA_W-1:0] ay,
      logic [ffthr_pkg::DATA_W-1:0] az);
    longint unsigned g, s, mag, base, den, t;
    longint vz;
    g = (grav == 0) ? 1 : grav;
    vz = sx(az) + longint'(g);
    s = longint'(sx(ax) * sx(ax)) + longint'(sx(ay) * sx(ay)) + longint'(vz * vz);
    mag = int_sqrt(s << 12);
    base = (hover_base != 0) ? hover_base : hover_col;
    den = g << 6;
    t = (base * mag + (den >> 1)) / den;
    if (t > thr_max) t = thr_max;
    return t[ffthr_pkg::THR_W-1:0];
  endfunction

  function automatic setpoint_ff_t predict_ff(logic [167:0] d, logic vreq);
    setpoint_ff_t e;
    logic [ffthr_pkg::DATA_W-1:0] f [ffthr_pkg::NUM_LANES];
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++)
      f[i] = d[i*ffthr_pkg::DATA_W +: ffthr_pkg::DATA_W];
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) e.ff[i] = '0;
    e.thrust = '0;
    e.en = 1'b0;
    if (vreq) begin
      for (int i = 0; i < 3; i++) e.ff[i] = scale_lane(f[i], vel_gain);
      for (int i = 3; i < 6; i++) e.ff[i] = scale_lane(f[i], acc_gain);
      e.ff[6] = scale_lane(f[6], yaw_gain_r);
      e.thrust = thrust_from_accel(f[3], f[4], f[5]);
      e.en = 1'b1;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // register shadow, input prediction, output compare
  always @(posedge clk) begin
    setpoint_ff_t e;
    if (rst) begin
      vel_gain <= ffthr_pkg::RST_GAIN; acc_gain <= ffthr_pkg::RST_GAIN;
      yaw_gain_r <= ffthr_pkg::RST_GAIN;
      grav <= ffthr_pkg::RST_GRAVITY; hover_col <= ffthr_pkg::RST_HOVER_COL;
      hover_base <= '0;
      thr_max <= ffthr_pkg::RST_THR_MAX;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffthr_pkg::REG_VEL_GAIN:   vel_gain   <= cfg_data[ffthr_pkg::GAIN_W-1:0];
          ffthr_pkg::REG_ACC_GAIN:   acc_gain   <= cfg_data[ffthr_pkg::GAIN_W-1:0];
          ffthr_pkg::REG_YAW_GAIN:   yaw_gain_r <= cfg_data[ffthr_pkg::GAIN_W-1:0];
          ffthr_pkg::REG_GRAVITY:    grav       <= cfg_data;
          ffthr_pkg::REG_HOVER_COL:  hover_col  <= cfg_data[ffthr_pkg::THR_W-1:0];
          ffthr_pkg::REG_HOVER_BASE: hover_base <= cfg_data[ffthr_pkg::THR_W-1:0];
          ffthr_pkg::REG_THRUST_MAX: thr_max    <= cfg_data[ffthr_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        ff_queue.push_back(predict_ff(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        if (ff_queue.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[63:0], 0);
        end else begin
          e = ff_queue.pop_front();
          for (int i = 0; i < ffthr_pkg::NUM_LANES; i++)
            if (m_axis_tdata[i*ffthr_pkg::DATA_W +: ffthr_pkg::DATA_W] !== e.ff[i])
              report_mismatch($sformatf("lane%0d", i),
                              m_axis_tdata[i*ffthr_pkg::DATA_W +: ffthr_pkg::DATA_W],
                              e.ff[i]);
          if (m_axis_tdata[ffthr_pkg::NUM_LANES*ffthr_pkg::DATA_W +: ffthr_pkg::THR_W]
              !== e.thrust)
            report_mismatch("thrust_ff",
                            m_axis_tdata[ffthr_pkg::NUM_LANES*ffthr_pkg::DATA_W +:
                                         ffthr_pkg::THR_W],
                            e.thrust);
          if (m_axis_tuser !== e.en)
            report_mismatch("enabled", m_axis_tuser, e.en);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int PIPE_LAT    = 51;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [183:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [19:0]  cfg_data = '0;
  int           fail_count, pending;
  int           src_idle_pct = 0, snk_idle_pct = 0;
  int           quiet_cycles = 0;

  always #2 clk = ~clk;

  flight_feedforward_thrust DUT (.*);

  ffthr_checker u_checker (.*);

  // receiver stall pattern
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [ffthr_pkg::DATA_W-1:0] rand_field();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return (ffthr_pkg::DATA_W)'($urandom_range(4000)) - 24'd2000;
      3: return (ffthr_pkg::DATA_W)'($urandom_range(200000)) - 24'd100000;
      default: return (ffthr_pkg::DATA_W)'($urandom);
    endcase
  endfunction

  // valid stays up between back-to-back beats; idle cycles drop it
  task automatic send_beat(logic vreq,
      logic [ffthr_pkg::DATA_W-1:0] f [ffthr_pkg::NUM_LANES]);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= vreq;
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++)
      s_axis_tdata[i*ffthr_pkg::DATA_W +: ffthr_pkg::DATA_W] <= f[i];
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(int n);
    logic [ffthr_pkg::DATA_W-1:0] f [ffthr_pkg::NUM_LANES];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) f[i] = rand_field();
      // hovering-like vertical accel to exercise the thrust path near g
      if ($urandom_range(2) == 0)
        f[5] = (ffthr_pkg::DATA_W)'($urandom_range(20000)) - 24'd10000;
      send_beat($urandom_range(5) != 0, f);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] vg, logic [15:0] ag, logic [15:0] yg,
      logic [19:0] g, logic [15:0] hc, logic [15:0] hb, logic [15:0] tm);
    write_reg(ffthr_pkg::REG_VEL_GAIN, vg);
    write_reg(ffthr_pkg::REG_ACC_GAIN, ag);
    write_reg(ffthr_pkg::REG_YAW_GAIN, yg);
    write_reg(ffthr_pkg::REG_GRAVITY, g);
    write_reg(ffthr_pkg::REG_HOVER_COL, hc);
    write_reg(ffthr_pkg::REG_HOVER_BASE, hb);
    write_reg(ffthr_pkg::REG_THRUST_MAX, tm);
  endtask

  initial begin
    logic [ffthr_pkg::DATA_W-1:0] f [ffthr_pkg::NUM_LANES];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, invalid setpoint, zero and hover
    src_idle_pct = 37; snk_idle_pct = 87;
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) f[i] = 24'h7FFFFF;
    send_beat(1'b1, f);
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) f[i] = 24'h800000;
    send_beat(1'b1, f);
    send_beat(1'b0, f);
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) f[i] = '0;
    send_beat(1'b1, f);
    f[5] = -24'd251136;            // free fall: zero magnitude
    send_beat(1'b1, f);
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++)
      f[i] = 24'h555555 ^ (ffthr_pkg::DATA_W)'(i);
    send_beat(1'b1, f);
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) f[i] = 24'hAAAAAA;
    send_beat(1'b1, f);
    for (int i = 0; i < ffthr_pkg::NUM_LANES; i++) f[i] = -24'd1;
    send_beat(1'b1, f);
    // hold off until every result is back
    drain();

    // max gains, baseline supplied, wide clamp
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(12);
    drain();
    // gravity zero is treated as one, zero gains
    write_all(16'd0, 16'd0, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0);
    send_random(8);
    drain();
    write_reg(3'd7, 20'hFFFFF);     // unused index, ignored

    write_all(16'd4096, 16'd8192, 16'd2048, 20'hFFFFF, 16'd8192, 16'd0, 16'hFFFF);
    send_random(450);
    drain();

    src_idle_pct = 87; snk_idle_pct = 37;
    write_all(16'd1234, 16'd40000, 16'd4096, 20'd251136, 16'd12000, 16'd9000, 16'd20000);
    send_random(450);
    drain();

    src_idle_pct = 0; snk_idle_pct = 0;
    write_all(16'd4096, 16'd4096, 16'd4096, 20'd251136, 16'd8192, 16'd0, 16'd16384);
    send_random(500);
    drain();

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

/* flight_feedforward_thrust.f */
rtl/core/ffthr_pkg.sv
rtl/core/ffthr_front.sv
rtl/core/ffthr_sqrt_cell.sv
rtl/core/ffthr_div_cell.sv
rtl/core/flight_feedforward_thrust.sv
tb/sv/ffthr_checker.sv
tb/sv/tb_top.sv
